/* rtl/dtsp_pkg.sv */
// ----------------------------------------------------------------------------
// dtsp_pkg
// types, constants and the sample packing function of the pen-tablet port
// ----------------------------------------------------------------------------
package dtsp_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_t;

  localparam int unsigned REQ_W       = 2;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned READ_W      = 4;
  localparam int unsigned SHIFT_W     = 19;
  localparam int unsigned WORD_W      = 18;
  localparam int unsigned POS_W       = 9;

  localparam logic [7:0]  X_OFFSET    = 8'd8;
  localparam logic [8:0]  Y_OFFSET    = 9'd12;
  localparam logic [7:0]  Y_NEAR      = 8'd48;
  localparam logic [8:0]  Y_LIMIT     = 9'd239;
  localparam logic [15:0] Y_DIV15_MUL = 16'd137;
  localparam int unsigned Y_DIV15_SH  = 11;
  localparam logic [11:0] X_SCALE     = 12'd15;
  localparam logic [3:0]  READ_IDLE   = 4'h4;

  // x*240/256 + 8, y*256/240 - 12 (floored at 0), button / near bits
  function automatic logic [WORD_W-1:0] pack_sample(logic [7:0] x, logic [7:0] y,
                                                    logic btn);
    logic [11:0] xs;
    logic [15:0] yp;
    logic [4:0]  yq;
    logic [8:0]  ys;
    logic [7:0]  yf;
    logic [7:0]  xf;
    logic [1:0]  low;
    xs = {4'b0, x} * X_SCALE;
    xf = xs[11:4] + X_OFFSET;
    // y*16/15 = y + y/15
    yp = {8'b0, y} * Y_DIV15_MUL;
    yq = yp[Y_DIV15_SH +: 5];
    ys = {1'b0, y} + {4'b0, yq};
    if (ys > Y_OFFSET) begin
      yf = 8'(ys - Y_OFFSET);
    end else begin
      yf = 8'd0;
    end
    if (btn) begin
      low = 2'b11;
    end else if (y >= Y_NEAR) begin
      low = 2'b10;
    end else begin
      low = 2'b00;
    end
    return {xf, yf, low};
  endfunction

endpackage

/* rtl/drawing_tablet_serial_port.sv */
// ----------------------------------------------------------------------------
// drawing_tablet_serial_port
// serial pen-tablet port: pen samples, strobe/clock port writes, port reads
// ----------------------------------------------------------------------------
// Every item is registered on acceptance and handled from that register, so
// one item is taken per clock, limited only by the output register: a read
// yields one result, through the input and output registers; writes and
// samples yield none. A sample is packed when it arrives and, if valid and
// in range, loaded into the 19-bit shift register by the next write with the
// strobe bit low; writes with the strobe high shift on a rising clock bit. The
// input stalls only while a read waits for a full output register to drain.
module drawing_tablet_serial_port (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // write_data[7:0], read_port[8], sample_ok[9], pen_x[18:10], pen_y[27:19],
  // pen_down[28], zero fill
  input  logic [dtsp_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type[1:0]
  input  logic [dtsp_pkg::REQ_W-1:0]      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // read_data[3:0], zero fill
  output logic [dtsp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import dtsp_pkg::*;

  logic                  in_valid;
  logic [REQ_W-1:0]      in_req;
  logic [7:0]            in_wdata;
  logic                  in_port;
  logic                  in_ok;
  logic [POS_W-1:0]      in_x;
  logic [POS_W-1:0]      in_y;
  logic                  in_btn;

  logic                  out_free;
  logic                  advance;

  logic                  clock_seen;
  logic [SHIFT_W-1:0]    shift_word;
  logic [WORD_W-1:0]     packed_word;
  logic [READ_W-1:0]     read_value;
  logic                  sample_pending;
  logic                  pending_good;
  logic [WORD_W-1:0]     pending_word;
  logic [READ_W-1:0]     read_data;

  logic                  clock_seen_next;
  logic [SHIFT_W-1:0]    shift_word_next;
  logic [WORD_W-1:0]     packed_word_next;
  logic [READ_W-1:0]     read_value_next;
  logic                  sample_pending_next;
  logic                  pending_good_next;
  logic [WORD_W-1:0]     pending_word_next;
  logic                  out_load;
  logic [READ_W-1:0]     out_value;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && (in_req != REQ_READ || out_free);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = {{(OUT_DATA_W-READ_W){1'b0}}, read_data};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_req   <= s_axis_tuser;
      in_wdata <= s_axis_tdata[7:0];
      in_port  <= s_axis_tdata[8];
      in_ok    <= s_axis_tdata[9];
      in_x     <= s_axis_tdata[18:10];
      in_y     <= s_axis_tdata[27:19];
      in_btn   <= s_axis_tdata[28];
    end
  end

  always_comb begin
    clock_seen_next     = clock_seen;
    shift_word_next     = shift_word;
    packed_word_next    = packed_word;
    read_value_next     = read_value;
    sample_pending_next = sample_pending;
    pending_good_next   = pending_good;
    pending_word_next   = pending_word;
    out_load            = 1'b0;
    out_value           = read_value;
    if (advance) begin
      case (in_req)
        REQ_WRITE: begin
          if (in_wdata[0]) begin
            if (in_wdata[1] && !clock_seen) begin
              shift_word_next = {shift_word[SHIFT_W-2:0], 1'b0};
            end
            read_value_next = in_wdata[1] ? {~shift_word_next[SHIFT_W-1], 3'b000}
                                          : READ_IDLE;
            clock_seen_next = in_wdata[1];
          end else begin
            read_value_next = '0;
            if (sample_pending) begin
              sample_pending_next = 1'b0;
              if (pending_good) begin
                packed_word_next = pending_word;
              end
            end
            shift_word_next = {1'b0, packed_word_next};
          end
        end
        REQ_READ: begin
          out_load  = 1'b1;
          out_value = in_port ? read_value : '0;
        end
        REQ_SAMPLE: begin
          sample_pending_next = 1'b1;
          pending_good_next   = in_ok && !in_x[POS_W-1] && in_y <= Y_LIMIT;
          pending_word_next   = pack_sample(in_x[7:0], in_y[7:0], in_btn);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_seen     <= 1'b0;
      shift_word     <= '0;
      packed_word    <= '0;
      read_value     <= '0;
      sample_pending <= 1'b0;
      pending_good   <= 1'b0;
      pending_word   <= '0;
    end else begin
      clock_seen     <= clock_seen_next;
      shift_word     <= shift_word_next;
      packed_word    <= packed_word_next;
      read_value     <= read_value_next;
      sample_pending <= sample_pending_next;
      pending_good   <= pending_good_next;
      pending_word   <= pending_word_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_data <= out_value;
    end
  end

endmodule

/* test/tb_drawing_tablet_serial_port.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_drawing_tablet_serial_port
// Drives pen samples, strobe and clock port writes and port reads into the
// pen-tablet port, and predicts every read value from its own model of the
// pending sample, packed word and shift register. It runs directed corner
// items, then read-out frames mixed with random noise under
// several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------

import dtsp_pkg::*;

class tablet_scoreboard;
  bit        clock_seen;
  bit [18:0] shift_word;
  bit [17:0] packed_word;
  bit [3:0]  read_value;
  bit        sample_pending;
  bit        pending_ok;
  bit [8:0]  pending_x;
  bit [8:0]  pending_y;
  bit        pending_button;

  bit [3:0]    expected_reads[$];
  int unsigned mismatches;
  int unsigned reads_checked;
  int unsigned samples_taken;
  int unsigned words_loaded;
  int unsigned bits_shifted;
  int unsigned ignored_items;

  function bit [17:0] scale_position(bit [8:0] x, bit [8:0] y, bit btn);
    int unsigned yq;
    int unsigned xq;
    bit [17:0]   w;
    yq = y * 256 / 240;
    xq = x * 240 / 256 + 8;
    w  = (yq > 12) ? 18'((yq - 12) << 2) : 18'd0;
    w |= 18'(xq << 10);
    if (btn) begin
      w |= 18'h3;
    end else if (y >= 48) begin
      w |= 18'h2;
    end
    return w;
  endfunction

  function void apply_write(bit [7:0] wd);
    if (wd[0]) begin
      if (wd[1] && !clock_seen) begin
        shift_word = shift_word << 1;
        bits_shifted++;
      end
      read_value = wd[1] ? {~shift_word[18], 3'b000} : 4'h4;
      clock_seen = wd[1];
    end else begin
      read_value = 4'h0;
      if (sample_pending) begin
        sample_pending = 1'b0;
        if (pending_ok && pending_x <= 255 && pending_y <= 239)
          packed_word = scale_position(pending_x, pending_y, pending_button);
      end
      shift_word = {1'b0, packed_word};
      words_loaded++;
    end
  endfunction

  function void note_input(logic [1:0] kind, logic [31:0] data);
    case (kind)
      REQ_WRITE: begin
        apply_write(data[7:0]);
      end
      REQ_READ: begin
        expected_reads.push_back(data[8] ? read_value : 4'h0);
      end
      REQ_SAMPLE: begin
        sample_pending = 1'b1;
        pending_ok     = data[9];
        pending_x      = data[18:10];
        pending_y      = data[27:19];
        pending_button = data[28];
        samples_taken++;
      end
      default: begin
        ignored_items++;
      end
    endcase
  endfunction

  task report_mismatch(string msg);
    mismatches++;
    $display("[%0t] error: %s", $time, msg);
  endtask

  task check_result(logic [7:0] data);
    bit [3:0] want;
    if (expected_reads.size() == 0) begin
      report_mismatch($sformatf("unexpected read item %h", data));
    end else begin
      want = expected_reads.pop_front();
      reads_checked++;
      if (data[3:0] !== want)
        report_mismatch($sformatf("read_data %h, expected %h", data[3:0], want));
      if (data[7:4] !== 4'h0)
        report_mismatch($sformatf("fill bits %h, expected 0", data[7:4]));
    end
  endtask
endclass

module tb_drawing_tablet_serial_port;
  localparam logic [1:0]  REQ_UNUSED = 2'd3;
  localparam int unsigned LIMIT      = 500000;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = REQ_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;

  tablet_scoreboard sb = new;

  drawing_tablet_serial_port u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pack_fields(logic [7:0] wd, logic rp, logic ok,
                                              logic [8:0] x, logic [8:0] y,
                                              logic btn);
    return {3'b000, btn, y, x, ok, rp, wd};
  endfunction

  task automatic send_item(logic [1:0] kind, logic [31:0] data);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= data;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  task automatic port_write(logic [7:0] wd);
    send_item(REQ_WRITE, pack_fields(wd, 1'($urandom), 1'($urandom), 9'($urandom),
                                     9'($urandom), 1'($urandom)));
  endtask

  task automatic port_read(logic rp);
    send_item(REQ_READ, pack_fields(8'($urandom), rp, 1'($urandom), 9'($urandom),
                                    9'($urandom), 1'($urandom)));
  endtask

  task automatic pen_sample(logic ok, logic [8:0] x, logic [8:0] y, logic btn);
    send_item(REQ_SAMPLE, pack_fields(8'($urandom), 1'($urandom), ok, x, y, btn));
  endtask

  // sample, load, then clock out a random number of bits with reads in between
  task automatic send_frame();
    int unsigned nbits;
    logic [8:0]  x;
    logic [8:0]  y;
    x = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(255));
    y = ($urandom_range(7) == 0) ? 9'($urandom) : 9'($urandom_range(239));
    pen_sample($urandom_range(9) != 0, x, y, 1'($urandom));
    port_write({7'($urandom), 1'b0});
    nbits = $urandom_range(1, 19);
    repeat (nbits) begin
      port_write({6'($urandom), 2'b01});
      port_read($urandom_range(15) != 0);
      port_write({6'($urandom), 2'b11});
      port_read($urandom_range(15) != 0);
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned n_items);
    int unsigned start;
    idle_pct  = idle;
    stall_pct = stall;
    start     = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(9) < 7) begin
        send_frame();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom), {3'b000, 29'($urandom)});
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    port_read(1'b1);
    port_read(1'b0);
    send_item(REQ_UNUSED, 32'h1FFF_FFFF);
    pen_sample(1'b1, 9'd255, 9'd239, 1'b1);
    port_write(8'h02);
    port_write(8'h03);
    port_read(1'b1);
    port_write(8'h01);
    port_read(1'b1);
    pen_sample(1'b1, 9'd0, 9'd12, 1'b0);
    pen_sample(1'b1, 9'd256, 9'd0, 1'b0);
    port_write(8'hFC);
    port_write(8'hFF);
    port_read(1'b1);
    pen_sample(1'b0, 9'd10, 9'd10, 1'b1);
    port_write(8'h00);
    pen_sample(1'b1, 9'd100, 9'd240, 1'b0);
    port_write(8'h00);
    pen_sample(1'b1, 9'd1, 9'd47, 1'b0);
    port_write(8'h00);
    port_write(8'h03);
    port_read(1'b1);
    pen_sample(1'b1, 9'd511, 9'd511, 1'b1);
    port_write(8'h00);
    pen_sample(1'b1, 9'd200, 9'd48, 1'b0);
    port_write(8'h00);
    port_write(8'h01);
    port_write(8'h03);
    port_read(1'b1);

    run_phase(0, 0, 440);
    run_phase(86, 0, 440);
    run_phase(0, 86, 440);
    run_phase(34, 34, 440);
    s_axis_tvalid <= 1'b0;

    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.expected_reads.size() != 0)
      sb.report_mismatch($sformatf("%0d reads never returned", sb.expected_reads.size()));

    $display("run: %0d items sent, %0d reads checked, %0d samples, %0d ignored",
             items_sent, sb.reads_checked, sb.samples_taken, sb.ignored_items);
    $display("     %0d shift loads, %0d bit shifts, %0d mismatches",
             sb.words_loaded, sb.bits_shifted, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
